### design/assert_macros.svh
// Assertion macros shared by the page free-list allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("invariant violated");

// A condition that implies another in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication violated");

// A condition that implies another in the following cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

### design/pfl_pkg.sv
// Types and constants of the page free-list allocator.
`default_nettype none

package pfl_pkg;

   localparam int unsigned MAX_PAGES = 4096;
   localparam int unsigned ID_W      = 12;
   localparam int unsigned ADDR_W    = $clog2(MAX_PAGES);
   localparam int unsigned CNT_W     = $clog2(MAX_PAGES + 1);
   localparam int unsigned CMP_W     = (ID_W > CNT_W) ? ID_W : CNT_W;

   typedef enum logic {
      CMD_ALLOC   = 1'b0,
      CMD_RELEASE = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_INVALID      = 2'd1,
      STATUS_ALREADY_FREE = 2'd2,
      STATUS_FULL         = 2'd3
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   // One entry of the page store: the free flag and the link to the next free page.
   typedef struct packed {
      logic              is_free;
      logic [ADDR_W-1:0] link;
   } link_entry_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      link_entry_type    data;
   } ram_wr_type;

endpackage

`default_nettype wire

### design/pfl_if.sv
// Request and response channel interfaces of the page free-list allocator.
`default_nettype none

interface pfl_req_if;
   logic                     valid;
   logic                     ready;
   pfl_pkg::cmd_type         cmd;
   logic [pfl_pkg::ID_W-1:0] page_id;

   modport source (output valid, output cmd, output page_id, input ready);
   modport sink   (input valid, input cmd, input page_id, output ready);
endinterface

interface pfl_rsp_if;
   logic                     valid;
   logic                     ready;
   logic [pfl_pkg::ID_W-1:0] page_id_out;
   pfl_pkg::status_type      status;

   modport source (output valid, output page_id_out, output status, input ready);
   modport sink   (input valid, input page_id_out, input status, output ready);
endinterface

`default_nettype wire

### design/pfl_link_ram.sv
// Page store: free flag and next-free link per page, one read and one write port.
`default_nettype none

module pfl_link_ram (
   input  logic                           clock,
   input  logic                           rd_en,
   input  logic [pfl_pkg::ADDR_W-1:0]     rd_addr,
   output pfl_pkg::link_entry_type        rd_data,
   input  pfl_pkg::ram_wr_type            wr
);
   import pfl_pkg::*;

   link_entry_type mem [MAX_PAGES];
   link_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### design/page_free_list_allocator.sv
// Top level of the page free-list allocator: control, list registers and result register.
//
//   Channel  Dir  Handshake          Payload
//   req_ch   in   valid / ready      cmd, page_id
//   rsp_ch   out  valid / ready      page_id_out, status
//
// On accept the page store is read; in the execute state the block checks the entry,
// writes it back and loads the result register.
// A stalled result holds the block in its execute state, so items run one at a time.
// Reset is synchronous; the page store needs no clearing pass, because a page's entry
// is written when the page is first handed out, before any use of it.
`default_nettype none
`include "assert_macros.svh"

module page_free_list_allocator (
   input  logic      clock,
   input  logic      reset,
   pfl_req_if.sink   req_ch,
   pfl_rsp_if.source rsp_ch
);
   import pfl_pkg::*;

   state_type         state_ff, state_in;
   cmd_type           cmd_ff;
   logic [ID_W-1:0]   page_ff;

   logic [ADDR_W-1:0] head_ff, head_in;
   logic              head_valid_ff, head_valid_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]   rsp_page_ff, rsp_page_in;
   status_type        rsp_status_ff, rsp_status_in;

   logic              req_accept;
   logic              exec_go;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   link_entry_type    ram_rd_data;
   ram_wr_type        ram_wr;
   logic [CMP_W-1:0]  out_page;

   assign req_accept = req_ch.valid && req_ch.ready;
   // The execute state completes only when the result register is free or being drained.
   assign exec_go    = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ch.ready);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_go) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State machine outputs.
   always_comb begin
      req_ch.ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_ch.ready = 1'b1;
         ST_EXEC: req_ch.ready = 1'b0;
         default: req_ch.ready = 1'b0;
      endcase
   end

   // The store is read at the released page, or at the list head for an allocate.
   assign ram_rd_en   = req_accept;
   assign ram_rd_addr = (req_ch.cmd == CMD_RELEASE) ? ADDR_W'(req_ch.page_id) : head_ff;

   // Read-modify-write of the page store and update of the list registers.
   always_comb begin
      head_in       = head_ff;
      head_valid_in = head_valid_ff;
      count_in      = count_ff;
      rsp_page_in   = rsp_page_ff;
      rsp_status_in = rsp_status_ff;
      out_page      = '0;
      ram_wr.en     = 1'b0;
      ram_wr.addr   = head_ff;
      ram_wr.data   = '{is_free: 1'b0, link: ram_rd_data.link};

      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      if (exec_go) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = STATUS_OK;
         if (cmd_ff == CMD_ALLOC) begin
            if (head_valid_ff) begin
               // Pop the head; a zero link marks the tail of the list.
               out_page      = CMP_W'(head_ff);
               ram_wr.en     = 1'b1;
               ram_wr.addr   = head_ff;
               head_in       = ram_rd_data.link;
               head_valid_in = (ram_rd_data.link != '0);
            end else if (count_ff == CNT_W'(MAX_PAGES)) begin
               rsp_status_in = STATUS_FULL;
            end else begin
               // Hand out a fresh page and mark its entry as in use.
               out_page    = CMP_W'(count_ff);
               ram_wr.en   = 1'b1;
               ram_wr.addr = count_ff[ADDR_W-1:0];
               ram_wr.data = '{is_free: 1'b0, link: '0};
               count_in    = count_ff + CNT_W'(1);
            end
         end else begin
            if ((page_ff == '0) || (CMP_W'(page_ff) >= CMP_W'(count_ff))) begin
               rsp_status_in = STATUS_INVALID;
            end else if (ram_rd_data.is_free) begin
               rsp_status_in = STATUS_ALREADY_FREE;
            end else begin
               // Push the page; the head register is zero whenever the list is empty.
               ram_wr.en     = 1'b1;
               ram_wr.addr   = ADDR_W'(page_ff);
               ram_wr.data   = '{is_free: 1'b1, link: head_ff};
               head_in       = ADDR_W'(page_ff);
               head_valid_in = 1'b1;
            end
         end
         rsp_page_in = out_page[ID_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         head_valid_ff <= 1'b0;
         count_ff      <= CNT_W'(1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         head_valid_ff <= head_valid_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff  <= req_ch.cmd;
         page_ff <= req_ch.page_id;
      end
      rsp_page_ff   <= rsp_page_in;
      rsp_status_ff <= rsp_status_in;
   end

   pfl_link_ram u_link_ram (
      .clock   (clock),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data),
      .wr      (ram_wr)
   );

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.page_id_out = rsp_page_ff;
   assign rsp_ch.status      = rsp_status_ff;

   `ASSERT_IMPLIES(a_empty_head_zero, clock, reset, !head_valid_ff, head_ff == '0)
   `ASSERT_IMPLIES(a_head_not_meta, clock, reset, head_valid_ff, head_ff != '0)
   `ASSERT_ALWAYS(a_count_range, clock, reset, (count_ff != '0) && (count_ff <= CNT_W'(MAX_PAGES)))
   `ASSERT_NEXT(a_accept_to_exec, clock, reset, req_accept, state_ff == ST_EXEC)
   `ASSERT_IMPLIES(a_write_in_exec, clock, reset, ram_wr.en, exec_go)

endmodule

`default_nettype wire
